// ===== design/xcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XML comment stripper package
// Marker characters, shared types and the one-byte decision function used by
// the filter pass.
// ----------------------------------------------------------------------------
package xcs_pkg;

    localparam int WinDepth = 4;
    localparam int WinHeld  = WinDepth - 1;

    localparam logic [7:0] ChLt   = 8'h3C;
    localparam logic [7:0] ChBang = 8'h21;
    localparam logic [7:0] ChDash = 8'h2D;
    localparam logic [7:0] ChQues = 8'h3F;
    localparam logic [7:0] ChGt   = 8'h3E;

    typedef logic [7:0] byte_t;

    // Scanner state kept between beats.
    typedef struct packed {
        logic [1:0] cnt;     // bytes held in the window, 0..3
        logic       in_cmt;  // between an opener and its closer
        logic [1:0] skip;    // marker bytes still to drop
    } scan_t;

    // Outcome of deciding one byte.
    typedef struct packed {
        logic       keep;
        logic       in_cmt;
        logic [1:0] skip;
    } step_t;

    // Results of one input beat.
    typedef struct packed {
        logic [2:0] cnt;     // number of output beats, 0..4
        logic       last;    // final beat of the run carries tlast
        logic       dummy;   // single empty beat that only carries tlast
    } res_t;

    // Decide the front byte b0 with avail bytes visible from b0 onward.
    function automatic step_t xcs_step(
        input logic [1:0] skip,
        input logic       in_cmt,
        input logic [2:0] avail,
        input byte_t      b0,
        input byte_t      b1,
        input byte_t      b2,
        input byte_t      b3
    );
        step_t r;
        r.keep   = 1'b0;
        r.in_cmt = in_cmt;
        r.skip   = skip;
        if (skip != 2'd0)
        begin
            r.skip = skip - 2'd1;
        end
        else if (in_cmt)
        begin
            if (avail >= 3'd3 && b0 == ChDash && b1 == ChDash && b2 == ChGt)
            begin
                r.skip   = 2'd2;
                r.in_cmt = 1'b0;
            end
            else if (avail >= 3'd2 && b0 == ChQues && b1 == ChGt)
            begin
                r.skip   = 2'd1;
                r.in_cmt = 1'b0;
            end
        end
        else
        begin
            if (avail >= 3'd4 && b0 == ChLt && b1 == ChBang &&
                b2 == ChDash && b3 == ChDash)
            begin
                r.skip   = 2'd3;
                r.in_cmt = 1'b1;
            end
            else if (avail >= 3'd2 && b0 == ChLt && b1 == ChQues)
            begin
                r.skip   = 2'd1;
                r.in_cmt = 1'b1;
            end
            else
            begin
                r.keep = 1'b1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/xcs_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XML comment stripper filter pass
// Combinational decision for one input beat: appends the byte to the window,
// decides the oldest byte once the window is full (or drains the whole
// window on the last beat) and packs the kept bytes in order.
// ----------------------------------------------------------------------------
module xcs_filter
    import xcs_pkg::*;
(
    input  var byte_t win [WinHeld],
    input  var scan_t scan,
    input  var byte_t data_byte,
    input  var logic  end_of_stream,
    output var byte_t win_next [WinHeld],
    output var scan_t scan_next,
    output var byte_t res_bytes [WinDepth],
    output var res_t  res
);

    byte_t      ext [2*WinDepth-1];
    logic [2:0] n_total;
    step_t      st;
    logic [1:0] skip_v;
    logic       in_cmt_v;
    logic [2:0] k;
    logic       active;

    assign n_total = {1'b0, scan.cnt} + 3'd1;

    // Window with the new byte appended, padded with zeros beyond the end.
    always_comb
    begin
        for (int i = 0; i < 2*WinDepth-1; i++)
        begin
            if (i < WinHeld && 2'(i) < scan.cnt)
                ext[i] = win[i];
            else if (i < WinDepth && 3'(i) == n_total - 3'd1)
                ext[i] = data_byte;
            else
                ext[i] = 8'h00;
        end
    end

    // Up to four dependent decisions on the last beat, at most one otherwise.
    always_comb
    begin
        skip_v   = scan.skip;
        in_cmt_v = scan.in_cmt;
        k        = 3'd0;
        st       = '0;
        active   = 1'b0;
        for (int j = 0; j < WinDepth; j++)
            res_bytes[j] = 8'h00;
        for (int i = 0; i < WinDepth; i++)
        begin
            if (end_of_stream)
                active = 3'(i) < n_total;
            else
                active = (i == 0) && (n_total == 3'(WinDepth));
            st = xcs_step(skip_v, in_cmt_v, n_total - 3'(i),
                          ext[i], ext[i+1], ext[i+2], ext[i+3]);
            if (active)
            begin
                skip_v   = st.skip;
                in_cmt_v = st.in_cmt;
                if (st.keep)
                begin
                    res_bytes[k[1:0]] = ext[i];
                    k = k + 3'd1;
                end
            end
        end
    end

    always_comb
    begin
        win_next  = win;
        scan_next = scan;
        res.last  = end_of_stream;
        res.dummy = 1'b0;
        res.cnt   = k;
        if (end_of_stream)
        begin
            scan_next = '0;
            if (k == 3'd0)
            begin
                res.dummy = 1'b1;
                res.cnt   = 3'd1;
            end
        end
        else if (n_total == 3'(WinDepth))
        begin
            for (int j = 0; j < WinHeld; j++)
                win_next[j] = ext[j+1];
            scan_next.skip   = skip_v;
            scan_next.in_cmt = in_cmt_v;
        end
        else
        begin
            win_next[scan.cnt] = data_byte;
            scan_next.cnt      = scan.cnt + 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== design/xml_comment_stripper_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XML comment stripper core
// Streaming filter that removes comments and processing instructions.
// ----------------------------------------------------------------------------
// The core takes one document byte per beat on the slave side and drops every
// byte from an opener "<!--" or "<?" up to and including the first later
// closer "-->" or "?>"; either closer ends either opener. All other bytes,
// 0xFF included, pass through unchanged on the master side with tuser high.
// Matching looks ahead through a four-byte window, so the first three bytes
// of a document produce no output and each later byte releases at most one
// kept byte. The beat with tlast high drains the window: it produces one to
// four output beats, the final one with tlast high. If nothing is left to
// keep, a single beat with tdata zero, tuser low and tlast high closes the
// document. State then returns to its reset values for the next document.
// Rate: one input beat per cycle in steady flow; the decision for a beat is a
// single combinational pass between the window registers and the output
// buffer. The input stalls while two or more output beats are pending, or
// while one is pending and the master side does not take it in that cycle.
// This happens after a tlast beat, while its drain beats leave, or when the
// master side applies backpressure.
// ----------------------------------------------------------------------------
module xml_comment_stripper_core
    import xcs_pkg::*;
(
    input  var logic       clk,
    input  var logic       rst_n,
    // Slave side
    input  var logic       s_tvalid,
    output var logic       s_tready,
    input  var logic [7:0] s_tdata,   // [7:0] data_byte
    input  var logic       s_tlast,   // end_of_stream
    // Master side
    output var logic       m_tvalid,
    input  var logic       m_tready,
    output var logic [7:0] m_tdata,   // [7:0] out_byte
    output var logic       m_tuser,   // [0] byte_valid
    output var logic       m_tlast    // out_last
);

    // Look-ahead window and scanner state. Window bytes beyond the fill
    // count are never read, so they need no reset.
    byte_t win_reg  [WinHeld];
    byte_t win_next [WinHeld];
    scan_t scan_reg;
    scan_t scan_next;

    // Output buffer: pending result beats, oldest in entry zero.
    byte_t      obuf_reg [WinDepth];
    logic [2:0] ocnt_reg;
    logic       olast_reg;
    logic       odummy_reg;

    byte_t res_bytes [WinDepth];
    res_t  res;

    logic in_fire;
    logic out_fire;

    assign m_tvalid = (ocnt_reg != 3'd0);
    assign m_tdata  = obuf_reg[0];
    assign m_tuser  = ~odummy_reg;
    assign m_tlast  = olast_reg && (ocnt_reg == 3'd1);

    // A new beat may enter when the buffer is empty or its only beat leaves
    // in this cycle.
    assign s_tready = (ocnt_reg == 3'd0) || ((ocnt_reg == 3'd1) && m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    xcs_filter u_filter (
        .win           (win_reg),
        .scan          (scan_reg),
        .data_byte     (s_tdata),
        .end_of_stream (s_tlast),
        .win_next      (win_next),
        .scan_next     (scan_next),
        .res_bytes     (res_bytes),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= '0;
            ocnt_reg   <= 3'd0;
            olast_reg  <= 1'b0;
            odummy_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                scan_reg   <= scan_next;
                ocnt_reg   <= res.cnt;
                olast_reg  <= res.last;
                odummy_reg <= res.dummy;
            end
            else if (out_fire)
            begin
                ocnt_reg <= ocnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            win_reg  <= win_next;
            obuf_reg <= res_bytes;
        end
        else if (out_fire)
        begin
            for (int j = 0; j < WinDepth - 1; j++)
                obuf_reg[j] <= obuf_reg[j+1];
            obuf_reg[WinDepth-1] <= 8'h00;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 3'(WinDepth))
        else $error("output buffer count out of range");

    a_empty_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty beat without tlast");

    a_stall_on_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg > 3'd1 |-> !s_tready)
        else $error("input accepted while output backlog pending");

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tlast |=> scan_reg == '0 && m_tvalid)
        else $error("state not cleared after end of document");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the XML comment stripper core
// Drives whole documents into the slave side with random gaps, drains the
// master side with random stalls, and checks every output beat against a
// beat-accurate prediction of the filter kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
    import xcs_pkg::*;

    // One predicted output beat: the kept byte, its valid flag and tlast.
    typedef struct packed {
        byte_t data;
        logic  kept;
        logic  last;
    } out_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It tracks the look-ahead window, the comment flag and the
    // count of marker bytes still to drop, exactly as the filter must, and
    // queues the beats that each accepted input beat should release.
    // ------------------------------------------------------------------------
    class strip_board;
        byte_t     win [WinDepth];
        int        held;
        bit        in_comment;
        bit [1:0]  skip_left;
        out_beat_t awaited [$];
        int        mismatches;

        function new();
            clear_doc();
            mismatches = 0;
        endfunction

        function void clear_doc();
            held       = 0;
            in_comment = 1'b0;
            skip_left  = 2'd0;
            foreach (win[i])
            begin
                win[i] = 8'h00;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Append one expected beat at the back of the queue.
        function void queue_beat(byte_t d, logic v, logic l);
            out_beat_t b;
            b.data = d;
            b.kept = v;
            b.last = l;
            awaited.insert(awaited.size(), b);
        endfunction

        // Decide the oldest window byte with n bytes visible, then shift the
        // window by one. Returns 1 when the byte survives the filter.
        function bit decide_oldest(int n, output byte_t kept_byte);
            bit keep;
            int i;
            keep      = 1'b0;
            kept_byte = win[0];
            if (skip_left != 2'd0)
            begin
                skip_left = skip_left - 2'd1;
            end
            else if (in_comment)
            begin
                if (n >= 3 && win[0] == ChDash && win[1] == ChDash && win[2] == ChGt)
                begin
                    skip_left  = 2'd2;
                    in_comment = 1'b0;
                end
                else if (n >= 2 && win[0] == ChQues && win[1] == ChGt)
                begin
                    skip_left  = 2'd1;
                    in_comment = 1'b0;
                end
            end
            else
            begin
                if (n >= 4 && win[0] == ChLt && win[1] == ChBang &&
                    win[2] == ChDash && win[3] == ChDash)
                begin
                    skip_left  = 2'd3;
                    in_comment = 1'b1;
                end
                else if (n >= 2 && win[0] == ChLt && win[1] == ChQues)
                begin
                    skip_left  = 2'd1;
                    in_comment = 1'b1;
                end
                else
                begin
                    keep = 1'b1;
                end
            end
            for (i = 0; i < WinDepth - 1; i++)
            begin
                win[i] = win[i + 1];
            end
            win[WinDepth - 1] = 8'h00;
            held--;
            return keep;
        endfunction

        // Note one accepted input beat and queue the beats it releases.
        function void take_input(byte_t d, logic eos);
            byte_t     kb;
            int        produced;
            produced = 0;
            if (held < WinDepth)
            begin
                win[held] = d;
                held++;
            end
            if (!eos)
            begin
                if (held == WinDepth && decide_oldest(WinDepth, kb))
                begin
                    queue_beat(kb, 1'b1, 1'b0);
                end
                return;
            end
            // End of document: drain with only the bytes that remain visible.
            while (held > 0)
            begin
                if (decide_oldest(held, kb))
                begin
                    queue_beat(kb, 1'b1, 1'b0);
                    produced++;
                end
            end
            if (produced == 0)
            begin
                queue_beat(8'h00, 1'b0, 1'b1);
            end
            else
            begin
                awaited[awaited.size() - 1].last = 1'b1;
            end
            clear_doc();
        endfunction

        task report(string field, int got, int want);
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
            mismatches++;
        endtask

        // Compare one accepted output beat with the oldest expectation.
        task match_output(byte_t d, logic v, logic l);
            out_beat_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected beat", d, 0);
                return;
            end
            want = awaited.pop_front();
            if (d !== want.data)
            begin
                report("out_byte", d, want.data);
            end
            if (v !== want.kept)
            begin
                report("byte_valid", v, want.kept);
            end
            if (l !== want.last)
            begin
                report("out_last", l, want.last);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic  clk      = 1'b0;
    logic  rst_n    = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    byte_t s_tdata  = 8'h00;   // [7:0] data_byte
    logic  s_tlast  = 1'b0;    // end_of_stream
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    byte_t m_tdata;            // [7:0] out_byte
    logic  m_tuser;            // [0] byte_valid
    logic  m_tlast;            // out_last

    strip_board board = new();
    byte_t      doc_bytes [$];
    int         beats_sent = 0;
    bit         hold_req   = 1'b0;

    always #1 clk = ~clk;

    xml_comment_stripper_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Half the gaps are zero, most others are short and a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Document builders. Well-formed documents mix plain text with complete
    // comments and processing instructions; either closer may end either
    // opener, and the tail may be cut off inside a comment or a marker.
    // ------------------------------------------------------------------------
    function automatic void put_byte(byte_t b);
        doc_bytes.insert(doc_bytes.size(), b);
    endfunction

    function automatic byte_t text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return byte_t'($urandom_range(8'h61, 8'h7A));
        end
        else if (r < 8)
        begin
            return byte_t'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 4))
            0:       return ChLt;
            1:       return ChBang;
            2:       return ChDash;
            3:       return ChQues;
            default: return ChGt;
        endcase
    endfunction

    function automatic void add_text(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            put_byte(text_byte());
        end
    endfunction

    function automatic void add_opener();
        if ($urandom_range(0, 1) == 0)
        begin
            put_byte(ChLt);
            put_byte(ChBang);
            put_byte(ChDash);
            put_byte(ChDash);
        end
        else
        begin
            put_byte(ChLt);
            put_byte(ChQues);
        end
    endfunction

    function automatic void add_closer();
        if ($urandom_range(0, 1) == 0)
        begin
            put_byte(ChDash);
            put_byte(ChDash);
            put_byte(ChGt);
        end
        else
        begin
            put_byte(ChQues);
            put_byte(ChGt);
        end
    endfunction

    function automatic void build_doc();
        int target;
        int tail;
        doc_bytes.delete();
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 18);
        if ($urandom_range(0, 4) == 0)
        begin
            // Noise: bytes drawn from the whole range.
            while (doc_bytes.size() < target)
            begin
                put_byte(byte_t'($urandom_range(0, 255)));
            end
            return;
        end
        while (doc_bytes.size() < target)
        begin
            add_text($urandom_range(0, 5));
            if ($urandom_range(0, 2) != 0)
            begin
                add_opener();
                add_text($urandom_range(0, 4));
                add_closer();
            end
        end
        tail = $urandom_range(0, 9);
        if (tail == 0)
        begin
            // Comment left open at the end of the document.
            add_opener();
            add_text($urandom_range(0, 3));
        end
        else if (tail == 1)
        begin
            // Opener cut short by the end of the document.
            put_byte(ChLt);
            if ($urandom_range(0, 1) == 1)
            begin
                put_byte(ChBang);
                if ($urandom_range(0, 1) == 1)
                begin
                    put_byte(ChDash);
                end
            end
        end
        else if (tail == 2)
        begin
            // A lone closer fragment outside any comment is plain text.
            put_byte(ChDash);
            put_byte(ChGt);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Slave-side driver. A beat is offered after an optional gap and held
    // until it is accepted; tvalid stays high between back-to-back beats.
    // ------------------------------------------------------------------------
    task automatic send_beat(byte_t d, logic eos, bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        board.take_input(d, eos);
        beats_sent++;
    endtask

    task automatic send_doc(bit steady);
        int i;
        for (i = 0; i < doc_bytes.size(); i++)
        begin
            send_beat(doc_bytes[i], (i == doc_bytes.size() - 1), steady);
        end
    endtask

    task automatic load_doc(byte_t bytes[$]);
        doc_bytes = bytes;
    endtask

    // ------------------------------------------------------------------------
    // Master-side driver. It stalls at random, keeps tready high for stretches
    // of varying length, and on request holds off for a long run of cycles so
    // that the core fills up and stalls its slave side.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (250) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Output monitor: every accepted master-side beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.match_output(m_tdata, m_tuser, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed documents, random documents, drain.
    // ------------------------------------------------------------------------
    initial
    begin
        bit held_off;
        bit paused;
        held_off = 1'b0;
        paused   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Byte extremes, a dash comment closed by the other closer, kept text.
        load_doc('{8'h00, 8'hFF, ChLt, ChBang, ChDash, ChDash, 8'h61, ChQues, ChGt, 8'h42});
        send_doc(1'b0);
        // Processing instruction closed by the dash closer.
        load_doc('{ChLt, ChQues, 8'h78, ChDash, ChDash, ChGt, 8'h80});
        send_doc(1'b0);
        // Opener cut short by the end of the document: bytes are kept.
        load_doc('{ChLt, ChBang, ChDash});
        send_doc(1'b1);
        // Unterminated processing instruction: nothing kept, empty last beat.
        load_doc('{ChLt, ChQues});
        send_doc(1'b0);
        // Single-byte document.
        load_doc('{8'hFF});
        send_doc(1'b0);

        while (beats_sent < 410)
        begin
            build_doc();
            if (!held_off && beats_sent > 150)
            begin
                // Long master-side stall while documents keep flowing in.
                held_off = 1'b1;
                hold_req = 1'b1;
                send_doc(1'b1);
            end
            else
            begin
                send_doc($urandom_range(0, 3) == 0);
            end
            if (!paused && beats_sent > 300)
            begin
                // Quiet the slave side until every expected beat has come out.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (board.pending() != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        // Keep the monitor running so that a stray extra beat would be caught.
        repeat (10) @(posedge clk);
        if (board.mismatches == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog: a hang or a lost beat ends the run here.
    initial
    begin
        #400000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
`default_nettype wire
